// ----- hdl/sph_pkg.sv -----
package sph_pkg;

    // fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS      = 4;
    localparam int RAD_BITS       = 15;
    localparam int BOT_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    // reset radii: 150 and 350 in fixed point, saturated to the register range
    localparam longint RAD_MAX    = 64'd32767;
    localparam longint ACT_FULL   = 64'd150 << FRAC_BITS;
    localparam longint DEACT_FULL = 64'd350 << FRAC_BITS;
    localparam logic [RAD_BITS-1:0] RESET_ACT_RAD =
        RAD_BITS'((ACT_FULL > RAD_MAX) ? RAD_MAX : ACT_FULL);
    localparam logic [RAD_BITS-1:0] RESET_DEACT_RAD =
        RAD_BITS'((DEACT_FULL > RAD_MAX) ? RAD_MAX : DEACT_FULL);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ACT_RAD   = 2'd0,
        CFG_DEACT_RAD = 2'd1,
        CFG_BOTTOM    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_ON   = 2'd1,
        EV_OFF  = 2'd2
    } t_event;

    // accumulator start behaviour of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        ACC_KEEP = 2'd0,
        ACC_ZERO = 2'd1,
        ACC_LOAD = 2'd2
    } t_acc_mode;

    typedef struct packed {
        logic      start;
        logic      sub;
        t_acc_mode mode;
    } t_mac_ctl;

endpackage

// ----- hdl/sph_mac.sv -----
module sph_mac #(
    parameter int ACW  = 67,
    parameter int AW   = 48,
    parameter int BW   = 33,
    parameter int CNTW = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sph_pkg::t_mac_ctl      i_ctl,
    input  logic [AW-1:0]          i_a,
    input  logic [BW-1:0]          i_b,
    input  logic [CNTW-1:0]        i_nbits,
    input  logic signed [ACW-1:0]  i_preload,
    output logic signed [ACW-1:0]  o_acc,
    output logic                   o_idle
);
    import sph_pkg::*;

    logic                  r_busy;
    logic [CNTW-1:0]       r_cnt;
    logic [ACW-1:0]        r_a;
    logic [BW-1:0]         r_b;
    logic                  r_sub;
    logic signed [ACW-1:0] r_acc;

    // radix-2 shift and add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= ACW'(i_a);
            r_b   <= i_b;
            r_sub <= i_ctl.sub;
            unique case (i_ctl.mode)
                ACC_ZERO: r_acc <= '0;
                ACC_LOAD: r_acc <= i_preload;
                default:  r_acc <= r_acc;
            endcase
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_sub ? r_acc - $signed(r_a) : r_acc + $signed(r_a);
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_acc  = r_acc;
    assign o_idle = !r_busy;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("mac started while busy");

    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (i_nbits != '0))
        else $error("mac started with zero length");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("mac busy with empty count");

endmodule

// ----- hdl/segment_proximity_hysteresis_top.sv -----
// per segment: squared length, dot product, then for an endpoint the squared distance
// and both radius checks, or for an inside point the cross product, its square and both
// radius comparisons; a new segment waits until the last is through, since the single
// shift-add multiply-accumulate unit, one multiplier bit per cycle, sets the pace
// a closing segment's result is registered in the finish state once the output can take it
// reset: synchronous active low; flag off, frame records clear, radii 150 and 350
module segment_proximity_hysteresis_top #(
    parameter int COORD_BITS = sph_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // segment beats
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_BITS-1:0]          i_point_x,
    input  logic signed [COORD_BITS-1:0]          i_point_y,
    input  logic signed [COORD_BITS-1:0]          i_seg_a_x,
    input  logic signed [COORD_BITS-1:0]          i_seg_a_y,
    input  logic signed [COORD_BITS-1:0]          i_seg_b_x,
    input  logic signed [COORD_BITS-1:0]          i_seg_b_y,
    input  logic                                  i_last_segment,
    // frame result beats
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_prox_on,
    output logic [1:0]                            o_change_event,
    output logic                                  o_near_bottom,
    // register writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sph_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [sph_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import sph_pkg::*;

    // widths of the exact arithmetic
    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;             // signed coordinate difference
    localparam int MW   = CW;                 // magnitude of a difference
    localparam int AB2W = 2 * CW + 1;         // squared segment length
    localparam int C2W  = 4 * CW + 2;         // squared cross product
    localparam int TW   = AB2W + RAD_BITS;    // length squared times radius
    localparam int TRW  = TW + RAD_BITS;      // length squared times radius squared
    localparam int ACW  = ((C2W > TRW) ? C2W : TRW) + 1;
    localparam int AW   = TW;
    localparam int BW   = AB2W;
    localparam int CNTW = $clog2(BW + 1);
    localparam int BCW  = (CW > BOT_BITS) ? CW : BOT_BITS;

    // one pass of the shared unit per state, except idle, case and finish
    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_AB2_X = 18'h00002,
        S_AB2_Y = 18'h00004,
        S_DOT_X = 18'h00008,
        S_DOT_Y = 18'h00010,
        S_CASE  = 18'h00020,
        S_PT_X  = 18'h00040,
        S_PT_Y  = 18'h00080,
        S_RAD_A = 18'h00100,
        S_RAD_D = 18'h00200,
        S_CR_X  = 18'h00400,
        S_CR_Y  = 18'h00800,
        S_CR_SQ = 18'h01000,
        S_T_A   = 18'h02000,
        S_CMP_A = 18'h04000,
        S_T_D   = 18'h08000,
        S_CMP_D = 18'h10000,
        S_FIN   = 18'h20000
    } t_state;

    function automatic logic [MW-1:0] f_mag(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] neg;
        neg = -v;
        return v[DW-1] ? MW'(neg) : MW'(v);
    endfunction

    t_state r_state, n_state;
    logic   r_issue;

    // configuration
    logic [RAD_BITS-1:0]        r_act_rad;
    logic [RAD_BITS-1:0]        r_deact_rad;
    logic signed [BOT_BITS-1:0] r_bottom;

    // item held for the whole computation
    logic signed [DW-1:0] r_apx, r_apy, r_abx, r_aby, r_bpx, r_bpy;
    logic signed [CW-1:0] r_py;
    logic                 r_last;

    // intermediate results
    logic [AB2W-1:0] r_ab2;
    logic [MW-1:0]   r_dx, r_dy;
    logic [BW-1:0]   r_cmag;
    logic [C2W-1:0]  r_ref;      // squared distance or squared cross product
    logic [TW-1:0]   r_t;
    logic            r_in_act, r_in_deact;

    // frame state
    logic r_any_act, r_any_deact, r_prox;

    logic [MW-1:0] m_apx, m_apy, m_abx, m_aby, m_bpx, m_bpy;
    logic          w_accept, w_step, w_out_ok;
    logic          w_any_act, w_any_deact;
    logic          w_acc_le0, w_dot_ge, w_ends_a;
    logic signed [ACW-1:0] w_acc, w_acc_mag;

    t_mac_ctl              w_ctl;
    logic [AW-1:0]         w_mac_a;
    logic [BW-1:0]         w_mac_b;
    logic [CNTW-1:0]       w_mac_n;
    logic signed [ACW-1:0] w_preload;
    logic                  w_mac_idle;

    assign m_apx = f_mag(r_apx);
    assign m_apy = f_mag(r_apy);
    assign m_abx = f_mag(r_abx);
    assign m_aby = f_mag(r_aby);
    assign m_bpx = f_mag(r_bpx);
    assign m_bpy = f_mag(r_bpy);

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_step      = !r_issue && w_mac_idle;
    assign w_out_ok    = !o_valid || !i_stall;

    assign w_acc_le0 = w_acc[ACW-1] || (w_acc == '0);
    assign w_dot_ge  = (w_acc >= $signed(ACW'(r_ab2)));
    // degenerate segment or projection at or before A: closest point is A
    assign w_ends_a  = (r_ab2 == '0) || w_acc_le0;
    assign w_acc_mag = w_acc[ACW-1] ? -w_acc : w_acc;

    assign w_any_act   = r_any_act || r_in_act;
    assign w_any_deact = r_any_deact || r_in_deact;

    // operands for the shared unit, chosen by the sequencer state
    always_comb begin
        w_ctl.start = r_issue && (r_state != S_IDLE) && (r_state != S_CASE)
                      && (r_state != S_FIN);
        w_ctl.sub   = 1'b0;
        w_ctl.mode  = ACC_KEEP;
        w_mac_a     = '0;
        w_mac_b     = '0;
        w_mac_n     = CNTW'(CW);
        w_preload   = $signed(ACW'(r_ref));
        unique case (r_state)
            S_AB2_X: begin
                w_mac_a    = AW'(m_abx);
                w_mac_b    = BW'(m_abx);
                w_ctl.mode = ACC_ZERO;
            end
            S_AB2_Y: begin
                w_mac_a = AW'(m_aby);
                w_mac_b = BW'(m_aby);
            end
            S_DOT_X: begin
                w_mac_a    = AW'(m_apx);
                w_mac_b    = BW'(m_abx);
                w_ctl.sub  = r_apx[DW-1] ^ r_abx[DW-1];
                w_ctl.mode = ACC_ZERO;
            end
            S_DOT_Y: begin
                w_mac_a   = AW'(m_apy);
                w_mac_b   = BW'(m_aby);
                w_ctl.sub = r_apy[DW-1] ^ r_aby[DW-1];
            end
            S_PT_X: begin
                w_mac_a    = AW'(r_dx);
                w_mac_b    = BW'(r_dx);
                w_ctl.mode = ACC_ZERO;
            end
            S_PT_Y: begin
                w_mac_a = AW'(r_dy);
                w_mac_b = BW'(r_dy);
            end
            S_RAD_A: begin
                w_mac_a    = AW'(r_act_rad);
                w_mac_b    = BW'(r_act_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.sub  = 1'b1;
                w_ctl.mode = ACC_LOAD;
            end
            S_RAD_D: begin
                w_mac_a    = AW'(r_deact_rad);
                w_mac_b    = BW'(r_deact_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.sub  = 1'b1;
                w_ctl.mode = ACC_LOAD;
            end
            S_CR_X: begin
                w_mac_a    = AW'(m_apx);
                w_mac_b    = BW'(m_aby);
                w_ctl.sub  = r_apx[DW-1] ^ r_aby[DW-1];
                w_ctl.mode = ACC_ZERO;
            end
            S_CR_Y: begin
                // cross product takes the negated term
                w_mac_a   = AW'(m_apy);
                w_mac_b   = BW'(m_abx);
                w_ctl.sub = !(r_apy[DW-1] ^ r_abx[DW-1]);
            end
            S_CR_SQ: begin
                w_mac_a    = AW'(r_cmag);
                w_mac_b    = r_cmag;
                w_mac_n    = CNTW'(BW);
                w_ctl.mode = ACC_ZERO;
            end
            S_T_A: begin
                w_mac_a    = AW'(r_ab2);
                w_mac_b    = BW'(r_act_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.mode = ACC_ZERO;
            end
            S_CMP_A: begin
                w_mac_a    = r_t;
                w_mac_b    = BW'(r_act_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.sub  = 1'b1;
                w_ctl.mode = ACC_LOAD;
            end
            S_T_D: begin
                w_mac_a    = AW'(r_ab2);
                w_mac_b    = BW'(r_deact_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.mode = ACC_ZERO;
            end
            S_CMP_D: begin
                w_mac_a    = r_t;
                w_mac_b    = BW'(r_deact_rad);
                w_mac_n    = CNTW'(RAD_BITS);
                w_ctl.sub  = 1'b1;
                w_ctl.mode = ACC_LOAD;
            end
            default: begin
            end
        endcase
    end

    sph_mac #(
        .ACW  (ACW),
        .AW   (AW),
        .BW   (BW),
        .CNTW (CNTW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_a       (w_mac_a),
        .i_b       (w_mac_b),
        .i_nbits   (w_mac_n),
        .i_preload (w_preload),
        .o_acc     (w_acc),
        .o_idle    (w_mac_idle)
    );

    // sequencer: each pass issues once, then waits for the unit to go idle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_AB2_X;
            S_AB2_X: if (w_step) n_state = S_AB2_Y;
            S_AB2_Y: if (w_step) n_state = S_DOT_X;
            S_DOT_X: if (w_step) n_state = S_DOT_Y;
            S_DOT_Y: if (w_step) n_state = S_CASE;
            S_CASE: begin
                if (w_ends_a || w_dot_ge) begin
                    n_state = S_PT_X;
                end else begin
                    n_state = S_CR_X;
                end
            end
            S_PT_X:  if (w_step) n_state = S_PT_Y;
            S_PT_Y:  if (w_step) n_state = S_RAD_A;
            S_RAD_A: if (w_step) n_state = S_RAD_D;
            S_RAD_D: if (w_step) n_state = S_FIN;
            S_CR_X:  if (w_step) n_state = S_CR_Y;
            S_CR_Y:  if (w_step) n_state = S_CR_SQ;
            S_CR_SQ: if (w_step) n_state = S_T_A;
            S_T_A:   if (w_step) n_state = S_CMP_A;
            S_CMP_A: if (w_step) n_state = S_T_D;
            S_T_D:   if (w_step) n_state = S_CMP_D;
            S_CMP_D: if (w_step) n_state = S_FIN;
            S_FIN:   if (!r_last || w_out_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_any_act   <= 1'b0;
            r_any_deact <= 1'b0;
            r_prox      <= 1'b0;
            o_valid     <= 1'b0;
            r_act_rad   <= RESET_ACT_RAD;
            r_deact_rad <= RESET_DEACT_RAD;
            r_bottom    <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= (n_state != r_state);

            // a new frame result may replace the one taken in this cycle
            if (r_state == S_FIN && r_last && w_out_ok) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end

            if (r_state == S_FIN) begin
                if (!r_last) begin
                    r_any_act   <= w_any_act;
                    r_any_deact <= w_any_deact;
                end else if (w_out_ok) begin
                    // hysteresis: on needs the inner radius, off needs nothing in the outer
                    if (!r_prox) begin
                        if (w_any_act) begin
                            r_prox <= 1'b1;
                        end
                    end else if (!w_any_deact) begin
                        r_prox <= 1'b0;
                    end
                    r_any_act   <= 1'b0;
                    r_any_deact <= 1'b0;
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ACT_RAD:   r_act_rad   <= i_cfg_data[RAD_BITS-1:0];
                    CFG_DEACT_RAD: r_deact_rad <= i_cfg_data[RAD_BITS-1:0];
                    CFG_BOTTOM:    r_bottom    <= $signed(i_cfg_data[BOT_BITS-1:0]);
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_apx  <= DW'(i_point_x) - DW'(i_seg_a_x);
            r_apy  <= DW'(i_point_y) - DW'(i_seg_a_y);
            r_abx  <= DW'(i_seg_b_x) - DW'(i_seg_a_x);
            r_aby  <= DW'(i_seg_b_y) - DW'(i_seg_a_y);
            r_bpx  <= DW'(i_point_x) - DW'(i_seg_b_x);
            r_bpy  <= DW'(i_point_y) - DW'(i_seg_b_y);
            r_py   <= i_point_y;
            r_last <= i_last_segment;
        end

        if (w_step) begin
            unique case (r_state)
                S_AB2_Y: r_ab2      <= w_acc[AB2W-1:0];
                S_PT_Y:  r_ref      <= w_acc[C2W-1:0];
                S_RAD_A: r_in_act   <= w_acc_le0;
                S_RAD_D: r_in_deact <= w_acc_le0;
                S_CR_Y:  r_cmag     <= w_acc_mag[BW-1:0];
                S_CR_SQ: r_ref      <= w_acc[C2W-1:0];
                S_T_A:   r_t        <= w_acc[TW-1:0];
                S_CMP_A: r_in_act   <= w_acc_le0;
                S_T_D:   r_t        <= w_acc[TW-1:0];
                S_CMP_D: r_in_deact <= w_acc_le0;
                default: begin
                end
            endcase
        end

        if (r_state == S_CASE) begin
            if (w_ends_a) begin
                r_dx <= m_apx;
                r_dy <= m_apy;
            end else begin
                r_dx <= m_bpx;
                r_dy <= m_bpy;
            end
        end

        if (r_state == S_FIN && r_last && w_out_ok) begin
            o_near_bottom <= ($signed(BCW'(r_py)) >= $signed(BCW'(r_bottom)));
            if (!r_prox) begin
                o_prox_on      <= w_any_act;
                o_change_event <= w_any_act ? EV_ON : EV_NONE;
            end else begin
                o_prox_on      <= w_any_deact;
                o_change_event <= w_any_deact ? EV_NONE : EV_OFF;
            end
        end
    end

    a_event_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_change_event != EV_ON) || o_prox_on)
                    && ((o_change_event != EV_OFF) || !o_prox_on))
        else $error("change event disagrees with proximity flag");

    a_flag_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_prox_on == r_prox))
        else $error("reported flag differs from held flag");

    a_accept_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> w_mac_idle)
        else $error("segment taken while arithmetic unit busy");

endmodule

// ----- tb/sph_frame_checker.sv -----
`timescale 1ns / 100ps

module sph_frame_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_seg_valid,
    input  logic                              i_seg_stall,
    input  logic signed [15:0]                i_point_x,
    input  logic signed [15:0]                i_point_y,
    input  logic signed [15:0]                i_seg_a_x,
    input  logic signed [15:0]                i_seg_a_y,
    input  logic signed [15:0]                i_seg_b_x,
    input  logic signed [15:0]                i_seg_b_y,
    input  logic                              i_last_segment,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic                              i_prox_on,
    input  logic [1:0]                        i_change_event,
    input  logic                              i_near_bottom,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [sph_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [sph_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_outstanding
);
    import sph_pkg::*;

    typedef logic signed [15:0] t_coord;
    typedef logic [RAD_BITS-1:0] t_rad;

    typedef struct packed {
        logic   prox_on;
        t_event change_event;
        logic   near_bottom;
    } t_frame_result;

    t_frame_result expected_frames[$];

    t_rad                       act_rad;
    t_rad                       deact_rad;
    logic signed [BOT_BITS-1:0] bottom_y;
    logic                       prox_state;
    logic                       act_hit;
    logic                       deact_hit;
    int                         errors = 0;

    // is the closest point of segment a-b within rad of p, exactly
    function automatic bit seg_within(input t_coord px, input t_coord py,
                                      input t_coord ax, input t_coord ay,
                                      input t_coord bx, input t_coord by,
                                      input t_rad rad);
        longint abx, aby, apx, apy, ab2, dot, ex, ey, r2, cr;
        logic signed [127:0] cross_w, lhs, rhs;
        abx = longint'(bx) - longint'(ax);
        aby = longint'(by) - longint'(ay);
        apx = longint'(px) - longint'(ax);
        apy = longint'(py) - longint'(ay);
        ab2 = abx * abx + aby * aby;
        dot = apx * abx + apy * aby;
        r2  = longint'(rad) * longint'(rad);
        if (ab2 == 0 || dot <= 0) begin
            ex = apx;
            ey = apy;
        end else if (dot >= ab2) begin
            ex = longint'(px) - longint'(bx);
            ey = longint'(py) - longint'(by);
        end else begin
            // interior: cross^2 against r^2 * |ab|^2
            cr      = apx * aby - apy * abx;
            cross_w = cr;
            lhs     = cross_w * cross_w;
            rhs     = r2;
            rhs     = rhs * ab2;
            return lhs <= rhs;
        end
        return ex * ex + ey * ey <= r2;
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_result want;
        t_event        ev;
        if (!i_rst_n) begin
            act_rad    = RESET_ACT_RAD;
            deact_rad  = RESET_DEACT_RAD;
            bottom_y   = '0;
            prox_state = 1'b0;
            act_hit    = 1'b0;
            deact_hit  = 1'b0;
            expected_frames.delete();
        end else begin
            // result beat first: it always belongs to an older segment
            if (i_res_valid && !i_res_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("frame result beat with none expected");
                    errors++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_prox_on !== want.prox_on) begin
                        $error("prox_on: expected %0d, got %0d", want.prox_on, i_prox_on);
                        errors++;
                    end
                    if (i_change_event !== want.change_event) begin
                        $error("change_event: expected %0d, got %0d",
                               want.change_event, i_change_event);
                        errors++;
                    end
                    if (i_near_bottom !== want.near_bottom) begin
                        $error("near_bottom: expected %0d, got %0d",
                               want.near_bottom, i_near_bottom);
                        errors++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ACT_RAD:   act_rad   = i_cfg_data[RAD_BITS-1:0];
                    CFG_DEACT_RAD: deact_rad = i_cfg_data[RAD_BITS-1:0];
                    CFG_BOTTOM:    bottom_y  = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_seg_valid && !i_seg_stall) begin
                act_hit = act_hit | seg_within(i_point_x, i_point_y, i_seg_a_x, i_seg_a_y,
                                               i_seg_b_x, i_seg_b_y, act_rad);
                deact_hit = deact_hit | seg_within(i_point_x, i_point_y, i_seg_a_x,
                                                   i_seg_a_y, i_seg_b_x, i_seg_b_y,
                                                   deact_rad);
                if (i_last_segment) begin
                    ev = EV_NONE;
                    if (!prox_state) begin
                        if (act_hit) begin
                            prox_state = 1'b1;
                            ev = EV_ON;
                        end
                    end else if (!deact_hit) begin
                        prox_state = 1'b0;
                        ev = EV_OFF;
                    end
                    act_hit   = 1'b0;
                    deact_hit = 1'b0;
                    want.prox_on      = prox_state;
                    want.change_event = ev;
                    want.near_bottom  = (i_point_y >= bottom_y);
                    expected_frames.push_back(want);
                end
            end
        end
        o_fail_count  <= errors;
        o_outstanding <= expected_frames.size();
    end

endmodule

// ----- tb/tb_segment_proximity_hysteresis_top.sv -----
`timescale 1ns / 100ps

module tb_segment_proximity_hysteresis_top;
    import sph_pkg::*;

    localparam int CW         = COORD_BITS_DEF;
    localparam int CLK_PERIOD = 20;
    localparam int RESET_CYCLES = 11;
    // long enough to cover a worst-case segment still in flight
    localparam int SETTLE_CYCLES = 300;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RAND_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int COORD_MAX = (1 << (CW - 1)) - 1;
    localparam int COORD_MIN = -(1 << (CW - 1));
    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef logic signed [CW-1:0] t_coord;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    t_coord                   i_point_x = '0;
    t_coord                   i_point_y = '0;
    t_coord                   i_seg_a_x = '0;
    t_coord                   i_seg_a_y = '0;
    t_coord                   i_seg_b_x = '0;
    t_coord                   i_seg_b_y = '0;
    logic                     i_last_segment = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic                     o_prox_on;
    logic [1:0]               o_change_event;
    logic                     o_near_bottom;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_hold = 0;
    // when set, the segment side sends back to back
    bit calm_sender = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    segment_proximity_hysteresis_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_seg_a_x      (i_seg_a_x),
        .i_seg_a_y      (i_seg_a_y),
        .i_seg_b_x      (i_seg_b_x),
        .i_seg_b_y      (i_seg_b_y),
        .i_last_segment (i_last_segment),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_prox_on      (o_prox_on),
        .o_change_event (o_change_event),
        .o_near_bottom  (o_near_bottom),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // predicts every frame result and compares the result beats
    sph_frame_checker frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seg_valid    (i_valid),
        .i_seg_stall    (o_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_seg_a_x      (i_seg_a_x),
        .i_seg_a_y      (i_seg_a_y),
        .i_seg_b_x      (i_seg_b_x),
        .i_seg_b_y      (i_seg_b_y),
        .i_last_segment (i_last_segment),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_prox_on      (o_prox_on),
        .i_change_event (o_change_event),
        .i_near_bottom  (o_near_bottom),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // receiver back-pressure: mostly short stalls, a few long ones,
    // and now and then a long stretch with none at all
    always @(posedge i_clk) begin : stall_gen
        int pick;
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                i_stall    <= 1'b0;
                stall_hold <= $urandom_range(200, 1500);
            end else if (pick < 55) begin
                i_stall    <= 1'b0;
                stall_hold <= $urandom_range(0, 6);
            end else if (pick < 95) begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(0, 4);
            end else begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(20, 80);
            end
        end
    end

    // run guard
    initial begin : run_guard
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic t_coord clamp_coord(input int v);
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        if (v < COORD_MIN) return t_coord'(COORD_MIN);
        return t_coord'(v);
    endfunction

    // uniform in [-m, m]
    function automatic int spread(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_radius();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) return '0;
        if (pick < 16) return CFG_DATA_BITS'(RAD_MAX);
        // full width: the top bit must be dropped by the block
        if (pick < 26) return CFG_DATA_BITS'($urandom);
        return CFG_DATA_BITS'($urandom_range(0, 8000));
    endfunction

    // one segment beat; valid stays high into the next beat when there is no gap
    task automatic send_segment(input t_coord px, input t_coord py,
                                input t_coord ax, input t_coord ay,
                                input t_coord bx, input t_coord by,
                                input logic last);
        int gap, pick;
        i_valid        <= 1'b1;
        i_point_x      <= px;
        i_point_y      <= py;
        i_seg_a_x      <= ax;
        i_seg_a_y      <= ay;
        i_seg_b_x      <= bx;
        i_seg_b_y      <= by;
        i_last_segment <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pick = $urandom_range(0, 99);
        if (calm_sender || pick < 60) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 4);
        else if (pick < 98) gap = $urandom_range(5, 20);
        else gap = $urandom_range(40, 120);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // directed segment from plain integer coordinates
    task automatic send_fixed(input int px, input int py, input int ax, input int ay,
                              input int bx, input int by, input logic last);
        send_segment(t_coord'(px), t_coord'(py), t_coord'(ax), t_coord'(ay),
                     t_coord'(bx), t_coord'(by), last);
    endtask

    // stop sending until every frame result is in, then optionally let a
    // segment that produces no result finish as well
    task automatic drain_and_rest(input bit rest);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        if (rest) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register writes only with the block idle; the unused index goes first
    // with random data and must leave everything untouched
    task automatic program_regs(input logic [CFG_DATA_BITS-1:0] act_d,
                                input logic [CFG_DATA_BITS-1:0] deact_d,
                                input logic [CFG_DATA_BITS-1:0] bottom_d);
        logic [CFG_IDX_BITS-1:0]  idx [4];
        logic [CFG_DATA_BITS-1:0] val [4];
        idx[0] = CFG_UNUSED_IDX; val[0] = CFG_DATA_BITS'($urandom);
        idx[1] = CFG_ACT_RAD;    val[1] = act_d;
        idx[2] = CFG_DEACT_RAD;  val[2] = deact_d;
        idx[3] = CFG_BOTTOM;     val[3] = bottom_d;
        drain_and_rest(1'b1);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random segment around the frame point, or pure noise
    task automatic send_random_segment(input t_coord fx, input t_coord fy, input logic last);
        int pick, span;
        t_coord px, py, ax, ay, bx, by;
        pick = $urandom_range(0, 99);
        span = 1 << $urandom_range(4, 13);
        if (pick < 12) begin
            // noise: every bit of every coordinate free
            px = t_coord'($urandom);
            py = t_coord'($urandom);
            ax = t_coord'($urandom);
            ay = t_coord'($urandom);
            bx = t_coord'($urandom);
            by = t_coord'($urandom);
        end else begin
            px = fx;
            py = fy;
            // point drifting within the frame
            if (pick < 27) begin
                px = clamp_coord(fx + spread(span));
                py = clamp_coord(fy + spread(span));
            end
            ax = clamp_coord(px + spread(2 * span));
            ay = clamp_coord(py + spread(2 * span));
            if ($urandom_range(0, 7) == 0) begin
                // zero-length segment
                bx = ax;
                by = ay;
            end else begin
                bx = clamp_coord(ax + spread(3 * span));
                by = clamp_coord(ay + spread(3 * span));
            end
        end
        send_segment(px, py, ax, ay, bx, by, last);
    endtask

    initial begin : stimulus
        int phase_items, frame_len, pick;
        t_coord fx, fy;
        logic [CFG_DATA_BITS-1:0] bottom_d;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset radii 150 / 350 and bottom line 0 ---
        // extreme corners, far from the long diagonal
        send_fixed(32767, -32768, -32768, -32768, 32767, 32767, 1'b1);
        // zero-length segment exactly on the activate radius: switches on
        send_fixed(2400, 0, 0, 0, 0, 0, 1'b1);
        // exactly on the deactivate radius: stays on
        send_fixed(0, 5600, 0, 0, 0, 0, 1'b1);
        // one step beyond: switches off
        send_fixed(0, 5601, 0, 0, 0, 0, 1'b1);
        // closest point is end b, exactly on the activate radius
        send_fixed(3400, 0, 0, 0, 1000, 0, 1'b1);
        // interior projection exactly on the deactivate radius
        send_fixed(0, -5600, -1000, 0, 1000, 0, 1'b1);
        // three-beat frame, only the middle segment inside deactivate
        send_fixed(0, 5601, -1000, 0, 1000, 0, 1'b0);
        send_fixed(500, 5600, -1000, 0, 1000, 0, 1'b0);
        send_fixed(32767, 32767, -32768, 32767, -32768, 32767, 1'b1);
        // interior just outside: switches off
        send_fixed(0, -5601, -1000, 0, 1000, 0, 1'b1);
        // point moves within the frame: first beat near end a, closing beat far
        send_fixed(-1600, -1600, 0, 0, 100, 100, 1'b0);
        send_fixed(20000, -20000, 0, 0, 100, 100, 1'b1);

        // deactivate radius below activate radius, lowest bottom line
        program_regs(16'd5000, 16'd1000, 16'h8000);
        send_fixed(3000, 0, 0, 0, 0, 0, 1'b1);
        send_fixed(3000, 0, 0, 0, 0, 0, 1'b1);
        send_fixed(500, 0, 0, 0, 0, 0, 1'b1);

        // zero radii; deactivate written with only its dropped top bit set
        program_regs(16'd0, 16'h8000, 16'h7FFF);
        send_fixed(0, 32767, 0, 32767, 0, 32767, 1'b1);
        send_fixed(1, 32767, 0, 32767, 0, 32767, 1'b1);
        // projection factor exactly zero, point on end a
        send_fixed(5, -7, 5, -7, 100, -7, 1'b1);

        // largest radii, all-ones data words
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fixed(32767, 32767, -32768, -32768, -32768, 32767, 1'b1);
        send_fixed(0, 0, -32768, -32768, 32767, -32768, 1'b0);
        send_fixed(0, -1, -32768, -32768, 32767, -32768, 1'b1);
        send_fixed(-32768, -32768, 32767, 32767, 32767, 32767, 1'b1);

        // --- random phases, each with its own register setting ---
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) bottom_d = 16'h8000;
            else if (pick < 20) bottom_d = 16'h7FFF;
            else bottom_d = CFG_DATA_BITS'($urandom);
            program_regs(pick_radius(), pick_radius(), bottom_d);
            calm_sender = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) fx = t_coord'($urandom);
                else fx = t_coord'(spread(28000));
                if ($urandom_range(0, 4) == 0) fy = t_coord'($urandom);
                else fy = t_coord'(spread(28000));
                frame_len = $urandom_range(1, 6);
                for (int k = 0; k < frame_len; k++) begin
                    send_random_segment(fx, fy, k == frame_len - 1);
                    phase_items++;
                end
                // sender holds off until the block has nothing left to report
                if ($urandom_range(0, 29) == 0) drain_and_rest(1'b0);
            end
            // sometimes leave a frame open across the register change
            if ($urandom_range(0, 2) == 0) begin
                frame_len = $urandom_range(1, 3);
                for (int k = 0; k < frame_len; k++) send_random_segment(fx, fy, 1'b0);
            end
        end
        // close whatever frame is still open
        send_random_segment(fx, fy, 1'b1);

        drain_and_rest(1'b1);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
